// ===== hdl/maze_carve_backtracker_defines.svh =====
// Assertion macros used by the maze carver top file.
`ifndef MAZE_CARVE_BACKTRACKER_DEFINES_SVH
`define MAZE_CARVE_BACKTRACKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset
`define MCB_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("maze carver check failed");

// Next-cycle implication, sampled on the rising edge, off while in reset
`define MCB_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("maze carver check failed");

`endif

// ===== hdl/mcb_pkg.sv =====
package mcb_pkg;

  localparam int MCB_MAX_COLUMNS = 64;
  localparam int MCB_MAX_ROWS    = 64;

  // Command codes; the unused code behaves as a read
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  localparam logic [3:0] ALL_WALLS = 4'hF;

  typedef enum logic [2:0] {
    STS_STARTED      = 3'd0,
    STS_CARVED       = 3'd1,
    STS_BACKTRACKED  = 3'd2,
    STS_FINISHED     = 3'd3,
    STS_CELL_READ    = 3'd4,
    STS_OUT_OF_RANGE = 3'd5
  } mcb_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_STACK,
    S_STACK_WAIT,
    S_CELLS,
    S_EVAL,
    S_CARVE,
    S_READ_WAIT
  } mcb_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] random_value;
  } mcb_in_t;

  typedef struct packed {
    mcb_status_t status;
    logic [5:0]  result_x;
    logic [5:0]  result_y;
    logic [3:0]  walls;
    logic        visited_mark;
    logic [5:0]  last_visited_x;
    logic [5:0]  last_visited_y;
    logic [12:0] stack_depth;
  } mcb_out_t;

  // Grid size in use, already clamped to the legal range
  typedef struct packed {
    logic [6:0] used_cols;
    logic [6:0] used_rows;
  } mcb_cfg_t;

  // Modulo 3 of a byte: 4 mod 3 is 1, so the 2-bit digits simply add up
  function automatic logic [1:0] mcb_mod3(logic [7:0] v);
    logic [3:0] s;
    logic [1:0] m;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:       m = 2'd2;
      default:                       m = 2'd0;
    endcase
    return m;
  endfunction

  // Random value modulo the open-neighbour count (1 to 4)
  function automatic logic [1:0] mcb_rnd_mod(logic [7:0] v, logic [2:0] n);
    logic [1:0] k;
    case (n)
      3'd2:    k = {1'b0, v[0]};
      3'd3:    k = mcb_mod3(v);
      3'd4:    k = v[1:0];
      default: k = 2'd0;
    endcase
    return k;
  endfunction

  // Direction of the k-th open neighbour, counting up, right, down, left
  function automatic logic [1:0] mcb_pick_dir(logic [3:0] open, logic [1:0] k);
    logic [2:0] seen;
    logic [1:0] dir;
    seen = 3'd0;
    dir  = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (open[d]) begin
        if (seen == {1'b0, k}) dir = 2'(d);
        seen = seen + 3'd1;
      end
    end
    return dir;
  endfunction

endpackage

// ===== hdl/maze_carve_backtracker.sv =====
// Maze carver with a randomised depth-first backtracker. Pulse start with a command while busy
// is low; each command yields exactly one result, shown for one cycle with out_strobe, and the
// receiver cannot stall it. Cell state lives in a single-port-write, registered-read memory of
// 2^(address bits) words. After reset the block sweeps that memory once before taking commands;
// a start on the grid repeats the sweep, seeds the start cell and then answers. A read on the
// grid, or a step on an empty stack, answers through the read-wait state and the output register.
// A step examines each stack entry with a stack read and wait, reads of the top cell and its four
// neighbours, and a decision; it answers after the last of them, through a carve state when it
// carves, and a backtrack repeats the examination for every entry it pops. Configuration writes
// are always taken (cfg_ready stays high) and must only happen while the block is idle.
`include "maze_carve_backtracker_defines.svh"

module maze_carve_backtracker #(
  parameter int MAX_COLUMNS = mcb_pkg::MCB_MAX_COLUMNS,
  parameter int MAX_ROWS    = mcb_pkg::MCB_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mcb_pkg::mcb_in_t  in_data,
  output logic              out_strobe,
  output mcb_pkg::mcb_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data
);
  import mcb_pkg::*;

  localparam int XA = $clog2(MAX_COLUMNS < 64 ? MAX_COLUMNS : 64);
  localparam int YA = $clog2(MAX_ROWS < 64 ? MAX_ROWS : 64);
  localparam int AW = XA + YA;

  logic [6:0] cols_r, cols_nxt, rows_r, rows_nxt;
  mcb_cfg_t   cfg;

  // Take a register transfer
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMNS: cols_nxt = cfg_data;
        CFG_ROWS:    rows_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd64;
      rows_r <= 7'd64;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Clamp the grid size: zero acts as one, oversize acts as the maximum
  always_comb begin
    cfg.used_cols = (cols_r == 7'd0) ? 7'd1 :
                    ((9'(cols_r) > 9'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cols_r);
    cfg.used_rows = (rows_r == 7'd0) ? 7'd1 :
                    ((9'(rows_r) > 9'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_r);
  end

  logic          cell_we, stk_we;
  logic [AW-1:0] cell_waddr, cell_raddr, stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [4:0]    cell_wdata, cell_rdata;

  mcb_seq #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cell_we   (cell_we),
    .cell_waddr(cell_waddr),
    .cell_wdata(cell_wdata),
    .cell_raddr(cell_raddr),
    .cell_rdata(cell_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // Cell store: visited bit over four wall bits
  mcb_ram #(
    .WIDTH(5),
    .DEPTH(1 << AW)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  // Backtrack stack of cell addresses
  mcb_ram #(
    .WIDTH(AW),
    .DEPTH(1 << AW)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  // An accepted command either starts work or answers at once
  `MCB_ASSERT_NEXT(a_accept_acts, start && !busy, busy || out_strobe)
  // A carved cell is visited and sits on a non-empty stack
  `MCB_ASSERT_IMPL(a_carve_marks, out_strobe && out_data.status == STS_CARVED, out_data.visited_mark && out_data.stack_depth != 13'd0)
  // A fresh start leaves one entry and a closed cell
  `MCB_ASSERT_IMPL(a_start_depth, out_strobe && out_data.status == STS_STARTED, out_data.stack_depth == 13'd1 && out_data.walls == ALL_WALLS)

endmodule

// ===== hdl/mcb_ram.sv =====
module mcb_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mcb_seq.sv =====
module mcb_seq #(
  parameter int MAX_COLUMNS = mcb_pkg::MCB_MAX_COLUMNS,
  parameter int MAX_ROWS    = mcb_pkg::MCB_MAX_ROWS,
  localparam int XA = $clog2(MAX_COLUMNS < 64 ? MAX_COLUMNS : 64),
  localparam int YA = $clog2(MAX_ROWS < 64 ? MAX_ROWS : 64),
  localparam int AW = XA + YA
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mcb_pkg::mcb_in_t  in_data,
  input  mcb_pkg::mcb_cfg_t cfg,
  output logic              busy,
  output logic              out_strobe,
  output mcb_pkg::mcb_out_t out_data,
  output logic              cell_we,
  output logic [AW-1:0]     cell_waddr,
  output logic [4:0]        cell_wdata,
  output logic [AW-1:0]     cell_raddr,
  input  logic [4:0]        cell_rdata,
  output logic              stk_we,
  output logic [AW-1:0]     stk_waddr,
  output logic [AW-1:0]     stk_wdata,
  output logic [AW-1:0]     stk_raddr,
  input  logic [AW-1:0]     stk_rdata
);
  import mcb_pkg::*;

  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH = CW'(1) << AW;

  mcb_state_t     state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [2:0]     rc_r, rc_nxt;
  logic [AW-1:0]  top_r, top_nxt;
  logic [4:0]     top_word_r, top_word_nxt;
  logic [3:0]     open_r, open_nxt;
  logic           popping_r, popping_nxt;
  logic           seeding_r, seeding_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  last_r, last_nxt;
  logic [5:0]     sx_r, sx_nxt, sy_r, sy_nxt;
  logic [7:0]     rnd_r, rnd_nxt;
  logic [1:0]     dir_r, dir_nxt;
  mcb_status_t    rd_sts_r, rd_sts_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  mcb_out_t       out_r, out_nxt;

  function automatic logic [AW-1:0] addr_of(logic [5:0] x, logic [5:0] y);
    return {y[YA-1:0], x[XA-1:0]};
  endfunction

  // Stack-top coordinates and its four neighbours
  logic [5:0]    tx, ty;
  logic [6:0]    nb_x [4];
  logic [6:0]    nb_y [4];
  logic [3:0]    nb_in;
  logic [AW-1:0] probe_addr [5];

  assign tx = 6'(top_r[XA-1:0]);
  assign ty = 6'(top_r[AW-1:XA]);

  always_comb begin
    nb_x[0] = {1'b0, tx};         nb_y[0] = {1'b0, ty} - 7'd1;
    nb_x[1] = {1'b0, tx} + 7'd1;  nb_y[1] = {1'b0, ty};
    nb_x[2] = {1'b0, tx};         nb_y[2] = {1'b0, ty} + 7'd1;
    nb_x[3] = {1'b0, tx} - 7'd1;  nb_y[3] = {1'b0, ty};
    probe_addr[0] = top_r;
    for (int d = 0; d < 4; d++) begin
      // A step below zero wraps to 127, never inside the grid
      nb_in[d]        = (nb_x[d] < cfg.used_cols) && (nb_y[d] < cfg.used_rows);
      probe_addr[d+1] = addr_of(nb_x[d][5:0], nb_y[d][5:0]);
    end
  end

  // Carve decision from the collected neighbour flags
  logic [2:0]    open_cnt;
  logic [1:0]    pick_k, pick_dir, far_dir;
  logic [CW-1:0] count_dec;
  logic          accept, in_inside;

  assign open_cnt  = 3'($countones(open_r));
  assign pick_k    = mcb_rnd_mod(rnd_r, open_cnt);
  assign pick_dir  = mcb_pick_dir(open_r, pick_k);
  assign far_dir   = dir_r + 2'd2;
  assign count_dec = count_r - CW'(1);
  assign accept    = start && !busy;
  assign in_inside = ({1'b0, in_data.cell_x} < cfg.used_cols) &&
                     ({1'b0, in_data.cell_y} < cfg.used_rows);

  function automatic mcb_out_t pack_out(mcb_status_t sts, logic [5:0] x, logic [5:0] y,
                                        logic [4:0] word, logic [AW-1:0] last,
                                        logic [CW-1:0] cnt);
    mcb_out_t o;
    o.status         = sts;
    o.result_x       = x;
    o.result_y       = y;
    o.walls          = word[3:0];
    o.visited_mark   = word[4];
    o.last_visited_x = 6'(last[XA-1:0]);
    o.last_visited_y = 6'(last[AW-1:XA]);
    o.stack_depth    = 13'(cnt);
    return o;
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:      if (clr_r == AW'(DEPTH - CW'(1))) state_nxt = seeding_r ? S_SEED : S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_START: if (in_inside) state_nxt = S_CLEAR;
            CMD_STEP:  state_nxt = (count_r == '0) ? S_READ_WAIT : S_STACK;
            default:   if (in_inside) state_nxt = S_READ_WAIT;
          endcase
        end
      end
      S_SEED:       state_nxt = S_IDLE;
      S_STACK:      state_nxt = S_STACK_WAIT;
      S_STACK_WAIT: state_nxt = S_CELLS;
      S_CELLS:      if (rc_r == 3'd5) state_nxt = S_EVAL;
      S_EVAL: begin
        if (open_cnt != 3'd0) state_nxt = popping_r ? S_IDLE : S_CARVE;
        else                  state_nxt = (count_dec == '0) ? S_IDLE : S_STACK;
      end
      S_CARVE:      state_nxt = S_IDLE;
      S_READ_WAIT:  state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and results
  always_comb begin
    clr_nxt        = clr_r;
    rc_nxt         = rc_r;
    top_nxt        = top_r;
    top_word_nxt   = top_word_r;
    open_nxt       = open_r;
    popping_nxt    = popping_r;
    seeding_nxt    = seeding_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    rnd_nxt        = rnd_r;
    dir_nxt        = dir_r;
    rd_sts_nxt     = rd_sts_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    cell_we        = 1'b0;
    cell_waddr     = top_r;
    cell_wdata     = {1'b0, ALL_WALLS};
    cell_raddr     = top_r;
    stk_we         = 1'b0;
    stk_waddr      = count_r[AW-1:0];
    stk_wdata      = top_r;
    stk_raddr      = count_dec[AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        // Sweep every cell back to four walls, unvisited
        cell_we    = 1'b1;
        cell_waddr = clr_r;
        clr_nxt    = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          sx_nxt  = in_data.cell_x;
          sy_nxt  = in_data.cell_y;
          rnd_nxt = in_data.random_value;
          case (in_data.command)
            CMD_START: begin
              if (in_inside) begin
                seeding_nxt = 1'b1;
                clr_nxt     = '0;
              end else begin
                out_strobe_nxt = 1'b1;
                out_nxt = pack_out(STS_OUT_OF_RANGE, in_data.cell_x, in_data.cell_y,
                                   5'd0, last_r, count_r);
              end
            end
            CMD_STEP: begin
              popping_nxt = 1'b0;
              if (count_r == '0) begin
                // Empty stack: report the last visited cell
                cell_raddr = last_r;
                rd_sts_nxt = STS_FINISHED;
                sx_nxt     = 6'(last_r[XA-1:0]);
                sy_nxt     = 6'(last_r[AW-1:XA]);
              end
            end
            default: begin
              if (in_inside) begin
                cell_raddr = addr_of(in_data.cell_x, in_data.cell_y);
                rd_sts_nxt = STS_CELL_READ;
              end else begin
                out_strobe_nxt = 1'b1;
                out_nxt = pack_out(STS_OUT_OF_RANGE, in_data.cell_x, in_data.cell_y,
                                   5'd0, last_r, count_r);
              end
            end
          endcase
        end
      end
      S_SEED: begin
        cell_we        = 1'b1;
        cell_waddr     = addr_of(sx_r, sy_r);
        cell_wdata     = {1'b1, ALL_WALLS};
        stk_we         = 1'b1;
        stk_waddr      = '0;
        stk_wdata      = addr_of(sx_r, sy_r);
        count_nxt      = CW'(1);
        last_nxt       = addr_of(sx_r, sy_r);
        seeding_nxt    = 1'b0;
        out_strobe_nxt = 1'b1;
        out_nxt = pack_out(STS_STARTED, sx_r, sy_r, {1'b1, ALL_WALLS}, last_nxt, count_nxt);
      end
      S_STACK: begin
        stk_raddr = count_dec[AW-1:0];
      end
      S_STACK_WAIT: begin
        top_nxt = stk_rdata;
        rc_nxt  = 3'd0;
      end
      S_CELLS: begin
        // Issue the top and four neighbour reads, each captured as the next one is issued
        if (rc_r != 3'd5) cell_raddr = probe_addr[rc_r];
        if (rc_r == 3'd1) top_word_nxt = cell_rdata;
        for (int d = 0; d < 4; d++) begin
          if (rc_r == 3'(d + 2)) open_nxt[d] = nb_in[d] && !cell_rdata[4];
        end
        rc_nxt = rc_r + 3'd1;
      end
      S_EVAL: begin
        if (open_cnt != 3'd0) begin
          if (popping_r) begin
            out_strobe_nxt = 1'b1;
            out_nxt = pack_out(STS_BACKTRACKED, tx, ty, top_word_r, last_r, count_r);
          end else begin
            // Drop the wall on the stack-top side
            cell_we    = 1'b1;
            cell_waddr = top_r;
            cell_wdata = top_word_r & ~(5'd1 << pick_dir);
            dir_nxt    = pick_dir;
          end
        end else begin
          count_nxt   = count_dec;
          popping_nxt = 1'b1;
          if (count_dec == '0) begin
            out_strobe_nxt = 1'b1;
            out_nxt = pack_out(STS_BACKTRACKED, 6'd0, 6'd0, 5'd0, last_r, count_dec);
          end
        end
      end
      S_CARVE: begin
        // Mark the new cell, drop its facing wall and push it
        cell_we    = 1'b1;
        cell_waddr = probe_addr[3'(dir_r) + 3'd1];
        cell_wdata = {1'b1, ALL_WALLS & ~(4'd1 << far_dir)};
        if (count_r < DEPTH) begin
          stk_we    = 1'b1;
          stk_wdata = probe_addr[3'(dir_r) + 3'd1];
          count_nxt = count_r + CW'(1);
        end
        last_nxt       = probe_addr[3'(dir_r) + 3'd1];
        out_strobe_nxt = 1'b1;
        out_nxt = pack_out(STS_CARVED, nb_x[dir_r][5:0], nb_y[dir_r][5:0], cell_wdata,
                           last_nxt, count_nxt);
      end
      S_READ_WAIT: begin
        out_strobe_nxt = 1'b1;
        out_nxt = pack_out(rd_sts_r, sx_r, sy_r, cell_rdata, last_r, count_r);
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      rc_r         <= '0;
      popping_r    <= 1'b0;
      seeding_r    <= 1'b0;
      count_r      <= '0;
      last_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      rc_r         <= rc_nxt;
      popping_r    <= popping_nxt;
      seeding_r    <= seeding_nxt;
      count_r      <= count_nxt;
      last_r       <= last_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    top_word_r <= top_word_nxt;
    open_r     <= open_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    rnd_r      <= rnd_nxt;
    dir_r      <= dir_nxt;
    rd_sts_r   <= rd_sts_nxt;
    out_r      <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ===== verif/maze_carve_backtracker_tb.sv =====
`timescale 1ns / 100ps

module maze_carve_backtracker_tb;
  import mcb_pkg::*;

  localparam int CELLS       = MCB_MAX_COLUMNS * MCB_MAX_ROWS;
  localparam int CYCLE_LIMIT = 2000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mcb_in_t   in_data;
  logic      out_strobe;
  mcb_out_t  out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  maze_carve_backtracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the maze state
  logic [4:0]  maze_cells [CELLS];
  logic [11:0] path_slots [CELLS];
  int          path_depth;
  int          last_slot;
  logic [6:0]  columns_reg;
  logic [6:0]  rows_reg;
  int          nb_slot [4];
  int          nb_dir [4];

  mcb_in_t  pending_cmds [$];
  mcb_out_t expected_results [$];
  int       send_idle_pct;
  int       fail_count;
  int       cycle_count;
  bit       cmd_taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int grid_cols();
    int c;
    c = columns_reg;
    if (c < 1) c = 1;
    if (c > MCB_MAX_COLUMNS) c = MCB_MAX_COLUMNS;
    return c;
  endfunction

  function automatic int grid_rows();
    int r;
    r = rows_reg;
    if (r < 1) r = 1;
    if (r > MCB_MAX_ROWS) r = MCB_MAX_ROWS;
    return r;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < grid_cols() && y < grid_rows();
  endfunction

  // List unvisited neighbours, up, right, down, left
  function automatic int open_neighbours(int s);
    int x;
    int y;
    int nx;
    int ny;
    int n;
    x = s % MCB_MAX_COLUMNS;
    y = s / MCB_MAX_COLUMNS;
    n = 0;
    for (int d = 0; d < 4; d++) begin
      nx = x + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
      ny = y + ((d == 2) ? 1 : (d == 0) ? -1 : 0);
      if (on_grid(nx, ny) && !maze_cells[ny * MCB_MAX_COLUMNS + nx][4]) begin
        nb_slot[n] = ny * MCB_MAX_COLUMNS + nx;
        nb_dir[n]  = d;
        n++;
      end
    end
    return n;
  endfunction

  function automatic mcb_out_t cell_report(mcb_status_t st, int x, int y, logic [4:0] c);
    mcb_out_t r;
    r.status         = st;
    r.result_x       = 6'(x);
    r.result_y       = 6'(y);
    r.walls          = c[3:0];
    r.visited_mark   = c[4];
    r.last_visited_x = 6'(last_slot % MCB_MAX_COLUMNS);
    r.last_visited_y = 6'(last_slot / MCB_MAX_COLUMNS);
    r.stack_depth    = 13'(path_depth);
    return r;
  endfunction

  function automatic mcb_out_t slot_report(mcb_status_t st, int s);
    return cell_report(st, s % MCB_MAX_COLUMNS, s / MCB_MAX_COLUMNS, maze_cells[s]);
  endfunction

  // Work out the answer to one command and advance the shadow maze
  function automatic mcb_out_t carve_predict(mcb_in_t cmd);
    int x;
    int y;
    int s;
    int top;
    int n;
    int k;
    x = cmd.cell_x;
    y = cmd.cell_y;
    if (cmd.command == CMD_START) begin
      if (!on_grid(x, y)) return cell_report(STS_OUT_OF_RANGE, x, y, 5'd0);
      for (int i = 0; i < CELLS; i++) maze_cells[i] = {1'b0, ALL_WALLS};
      s = y * MCB_MAX_COLUMNS + x;
      maze_cells[s][4] = 1'b1;
      path_slots[0] = 12'(s);
      path_depth = 1;
      last_slot = s;
      return slot_report(STS_STARTED, s);
    end
    if (cmd.command == CMD_STEP) begin
      if (path_depth == 0) return slot_report(STS_FINISHED, last_slot);
      top = path_slots[path_depth - 1];
      n = open_neighbours(top);
      if (n > 0) begin
        k = cmd.random_value % n;
        s = nb_slot[k];
        maze_cells[s][4] = 1'b1;
        maze_cells[top][nb_dir[k]] = 1'b0;
        maze_cells[s][(nb_dir[k] + 2) % 4] = 1'b0;
        if (path_depth < CELLS) begin
          path_slots[path_depth] = 12'(s);
          path_depth++;
        end
        last_slot = s;
        return slot_report(STS_CARVED, s);
      end
      // Pop back to a cell that still has somewhere to go
      while (path_depth > 0 && open_neighbours(path_slots[path_depth - 1]) == 0)
        path_depth--;
      if (path_depth == 0) return cell_report(STS_BACKTRACKED, 0, 0, 5'd0);
      return slot_report(STS_BACKTRACKED, path_slots[path_depth - 1]);
    end
    if (!on_grid(x, y)) return cell_report(STS_OUT_OF_RANGE, x, y, 5'd0);
    return slot_report(STS_CELL_READ, y * MCB_MAX_COLUMNS + x);
  endfunction

  // Accept command and configuration transfers, predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), carve_predict(in_data));
        cmd_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLUMNS) columns_reg = cfg_data;
        else if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
      end
    end
  end

  // Drive commands from the pending queue, idling at random
  always @(negedge clk) begin
    if (rst_n && (cmd_taken || !start)) begin
      cmd_taken = 1'b0;
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_cmds.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    mcb_out_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result, status %0d", out_data.status);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          fail_count++;
        end
        if (out_data.result_x !== exp_r.result_x) begin
          $error("result_x expected %0d actual %0d", exp_r.result_x, out_data.result_x);
          fail_count++;
        end
        if (out_data.result_y !== exp_r.result_y) begin
          $error("result_y expected %0d actual %0d", exp_r.result_y, out_data.result_y);
          fail_count++;
        end
        if (out_data.walls !== exp_r.walls) begin
          $error("walls expected %0h actual %0h", exp_r.walls, out_data.walls);
          fail_count++;
        end
        if (out_data.visited_mark !== exp_r.visited_mark) begin
          $error("visited_mark expected %0d actual %0d", exp_r.visited_mark,
                 out_data.visited_mark);
          fail_count++;
        end
        if (out_data.last_visited_x !== exp_r.last_visited_x) begin
          $error("last_visited_x expected %0d actual %0d", exp_r.last_visited_x,
                 out_data.last_visited_x);
          fail_count++;
        end
        if (out_data.last_visited_y !== exp_r.last_visited_y) begin
          $error("last_visited_y expected %0d actual %0d", exp_r.last_visited_y,
                 out_data.last_visited_y);
          fail_count++;
        end
        if (out_data.stack_depth !== exp_r.stack_depth) begin
          $error("stack_depth expected %0d actual %0d", exp_r.stack_depth,
                 out_data.stack_depth);
          fail_count++;
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] c, int x, int y, int r);
    mcb_in_t item;
    item.command      = c;
    item.cell_x       = 6'(x);
    item.cell_y       = 6'(y);
    item.random_value = 8'(r);
    pending_cmds.insert(pending_cmds.size(), item);
  endtask

  // Hold until every transfer has been answered and the block is idle
  task automatic wait_drained();
    wait (pending_cmds.size() == 0 && !start && expected_results.size() == 0 && !busy);
    @(negedge clk);
  endtask

  // Write both grid registers back to back
  task automatic write_grid(logic [6:0] cols, logic [6:0] rows);
    logic [6:0] vals [2];
    vals[0] = cols;
    vals[1] = rows;
    for (int i = 0; i < 2; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_COLUMNS : CFG_ROWS;
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Carve sequences: starts, runs of steps, reads and some noise
  task automatic queue_random(int count);
    int r;
    logic [1:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (i == 0 || r < 4) begin
        if ($urandom_range(99) < 15)
          queue_cmd(CMD_START, $urandom_range(63), $urandom_range(63), $urandom);
        else
          queue_cmd(CMD_START, $urandom_range(grid_cols() - 1),
                    $urandom_range(grid_rows() - 1), $urandom);
      end else if (r < 14) begin
        c = ($urandom_range(4) == 0) ? CMD_SPARE : CMD_READ;
        if ($urandom_range(99) < 80)
          queue_cmd(c, $urandom_range(grid_cols() - 1),
                    $urandom_range(grid_rows() - 1), $urandom);
        else
          queue_cmd(c, $urandom_range(63), $urandom_range(63), $urandom);
      end else begin
        queue_cmd(CMD_STEP, $urandom_range(63), $urandom_range(63), $urandom_range(255));
      end
    end
  endtask

  initial begin
    logic [6:0] phase_cols [6];
    logic [6:0] phase_rows [6];
    int idle_modes [4];
    phase_cols = '{7'd64, 7'd8, 7'd2, 7'd127, 7'd1, 7'd16};
    phase_rows = '{7'd64, 7'd8, 7'd3, 7'd5, 7'd64, 7'd127};
    idle_modes = '{0, 86, 0, 24};
    for (int i = 0; i < CELLS; i++) begin
      maze_cells[i] = {1'b0, ALL_WALLS};
      path_slots[i] = '0;
    end
    path_depth    = 0;
    last_slot     = 0;
    columns_reg   = 7'd64;
    rows_reg      = 7'd64;
    fail_count    = 0;
    cycle_count   = 0;
    cmd_taken     = 1'b0;
    send_idle_pct = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COLUMNS;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset grid, empty stack, corners, unknown command
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_READ, 63, 63, 255);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_START, 63, 63, 0);
    queue_cmd(CMD_STEP, 0, 0, 255);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_STEP, 0, 0, 3);
    queue_cmd(CMD_SPARE, 63, 63, 0);
    queue_cmd(CMD_START, 0, 0, 255);
    queue_cmd(CMD_STEP, 0, 0, 1);
    queue_cmd(CMD_STEP, 0, 0, 2);
    queue_cmd(CMD_READ, 0, 0, 0);
    wait_drained();

    // Directed: zero registers act as a one-cell grid
    write_grid(7'd0, 7'd0);
    queue_cmd(CMD_READ, 5, 0, 0);
    queue_cmd(CMD_START, 1, 0, 0);
    queue_cmd(CMD_START, 0, 0, 0);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_START, 0, 63, 0);

    // Random phases over grid sizes and idling modes
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_grid(phase_cols[p], phase_rows[p]);
      send_idle_pct = idle_modes[p % 4];
      queue_random(190);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mcb_pkg.sv
hdl/mcb_ram.sv
hdl/mcb_seq.sv
hdl/maze_carve_backtracker.sv
verif/maze_carve_backtracker_tb.sv
